// ===== hdl/base64_line_wrapped_encoder_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH

// Check outside reset.
`define B64E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/b64e_pkg.sv =====
package b64e_pkg;

    localparam int LINE_CHARS_DEF = 76;
    localparam int LINE_W         = 7;
    localparam int FIFO_DEPTH_DEF = 2;
    localparam int IDX_W          = 3;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    localparam logic [IDX_W-1:0] IDX_GROUP_END = 3'd3;
    localparam logic [IDX_W-1:0] IDX_CR        = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LF        = 3'd5;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            crlf;
    } entry_t;

    function automatic logic [7:0] b64e_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'd65 + {2'b00, v};
            [6'd26:6'd51]: c = 8'd71 + {2'b00, v};
            [6'd52:6'd61]: c = {2'b00, v} - 8'd4;
            6'd62:         c = 8'd43;
            default:       c = 8'd47;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/base64_line_wrapped_encoder.sv =====
// Base64 encoder with CR LF line wrapping.
// Slave channel: one raw byte per beat; s_tlast marks the last byte of a message.
// Master channel: one ASCII character per beat; m_tlast marks the final character
// produced by an input byte (end of a group, of a padded remainder, or the LF).
// Bytes that only fill a group produce no output.
// With the queue empty and the output register free, the byte completing a group
// is written into the queue and its first character is then registered onto the
// master port; the rest follow one per cycle while the receiver takes them.
// The output register moves one character per cycle while the receiver takes
// them. A CR LF follows every 76 characters of a line; a padded remainder
// still yields four characters, so a one-byte message yields four.
// A two-entry group queue between the byte front end and the character back end
// absorbs bursts; s_tready falls only when that queue is full.
// When the receiver stalls, the output register holds its beat and the queue
// fills, then s_tready drops.
// Reset clears the group phase, the line count, the queue and the output valid.
module base64_line_wrapped_encoder #(
    parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF,
    parameter int FIFO_DEPTH = b64e_pkg::FIFO_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast
);
    import b64e_pkg::*;

    logic   full;
    logic   empty;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;

    assign s_tready = !full;

    b64e_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_tvalid && s_tready),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/b64e_front.sv =====
module b64e_front #(
    parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output logic            push,
    output b64e_pkg::entry_t push_entry
);
    import b64e_pkg::*;

    localparam logic [LINE_W:0] LINE_LIMIT = (LINE_W + 1)'(LINE_CHARS);

    logic [7:0]        first_reg, first_next;
    logic [7:0]        second_reg, second_next;
    logic [1:0]        phase_reg, phase_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LINE_W:0]   cnt;

    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        phase_next  = phase_reg;
        line_next   = line_reg;
        push        = 1'b0;
        push_entry  = '0;
        cnt         = {1'b0, line_reg} + (LINE_W + 1)'(4);
        if (accept)
        begin
            case (phase_reg)
                2'd0:
                begin
                    if (last_byte)
                    begin
                        push                = 1'b1;
                        push_entry.chars[0] = b64e_char(data_byte[7:2]);
                        push_entry.chars[1] = b64e_char({data_byte[1:0], 4'b0000});
                        push_entry.chars[2] = CHAR_PAD;
                        push_entry.chars[3] = CHAR_PAD;
                    end
                    else
                    begin
                        first_next = data_byte;
                        phase_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (last_byte)
                    begin
                        push                = 1'b1;
                        push_entry.chars[0] = b64e_char(first_reg[7:2]);
                        push_entry.chars[1] = b64e_char({first_reg[1:0], data_byte[7:4]});
                        push_entry.chars[2] = b64e_char({data_byte[3:0], 2'b00});
                        push_entry.chars[3] = CHAR_PAD;
                    end
                    else
                    begin
                        second_next = data_byte;
                        phase_next  = 2'd2;
                    end
                end
                default:
                begin
                    push                = 1'b1;
                    push_entry.chars[0] = b64e_char(first_reg[7:2]);
                    push_entry.chars[1] = b64e_char({first_reg[1:0], second_reg[7:4]});
                    push_entry.chars[2] = b64e_char({second_reg[3:0], data_byte[7:6]});
                    push_entry.chars[3] = b64e_char(data_byte[5:0]);
                    push_entry.crlf     = (cnt >= LINE_LIMIT);
                    phase_next          = 2'd0;
                    line_next           = push_entry.crlf ? '0 : cnt[LINE_W-1:0];
                end
            endcase
            if (last_byte)
            begin
                phase_next = 2'd0;
                line_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            line_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

endmodule

// ===== hdl/b64e_fifo.sv =====
module b64e_fifo #(
    parameter int DEPTH = b64e_pkg::FIFO_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64e_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output b64e_pkg::entry_t head
);
    import b64e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_FULL);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/b64e_back.sv =====
module b64e_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  b64e_pkg::entry_t head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import b64e_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    logic             load;
    logic             final_char;

    assign load       = (!valid_reg || m_tready) && !empty;
    assign final_char = head.crlf ? (idx_reg == IDX_LF) : (idx_reg == IDX_GROUP_END);
    assign pop        = load && final_char;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = final_char;
            idx_next   = final_char ? '0 : idx_reg + IDX_W'(1);
            case (idx_reg)
                IDX_CR:  char_next = CHAR_CR;
                IDX_LF:  char_next = CHAR_LF;
                default: char_next = head.chars[idx_reg[1:0]];
            endcase
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/b64e_checker.sv =====
`include "base64_line_wrapped_encoder_defines.svh"

module b64e_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);
    import b64e_pkg::*;

    logic legal_char;
    logic out_beat;
    logic out_stall;
    logic is_cr;
    logic is_lf;

    assign legal_char = (m_tdata >= 8'd65 && m_tdata <= 8'd90)
                     || (m_tdata >= 8'd97 && m_tdata <= 8'd122)
                     || (m_tdata >= 8'd48 && m_tdata <= 8'd57)
                     || m_tdata == 8'd43 || m_tdata == 8'd47
                     || m_tdata == CHAR_PAD || m_tdata == CHAR_CR || m_tdata == CHAR_LF;

    assign out_beat  = m_tvalid && m_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign is_cr     = (m_tdata == CHAR_CR);
    assign is_lf     = (m_tdata == CHAR_LF);

    `B64E_ASSERT_ALWAYS(a_reset_idle, (!rst_n |-> !m_tvalid), "output valid during reset")
    `B64E_ASSERT(a_hold, (out_stall |=> m_tvalid && $stable({m_tdata, m_tlast})), "beat not held")
    `B64E_ASSERT(a_alphabet, (m_tvalid |-> legal_char), "character outside Base64 text")
    `B64E_ASSERT(a_cr_lf, (out_beat && is_cr |=> m_tvalid && is_lf && m_tlast), "CR without LF")
    `B64E_ASSERT(a_cr_not_last, (m_tvalid && is_cr |-> !m_tlast), "CR marked last")

endmodule

bind base64_line_wrapped_encoder b64e_checker u_checker (.*);
